// ===== rtl/core/per_segment_class_histogram_unit_assert.svh =====
// Assertion macros for the per-segment class histogram unit.
`ifndef PER_SEGMENT_CLASS_HISTOGRAM_UNIT_ASSERT_SVH
`define PER_SEGMENT_CLASS_HISTOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PSCH_ASSERT_IMP(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication.
`define PSCH_ASSERT_NXT(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/psch_pkg.sv =====
// Types and constants of the per-segment class histogram unit.
package psch_pkg;

	localparam logic [63:0] HASH_MULT       = 64'h9E3779B97F4A7C15;
	localparam logic [17:0] CLASS_MAP_RESET = 18'd178719;
	localparam logic [31:0] MIN_TOTAL_RESET = 32'd1000;
	localparam logic [7:0]  MAX_LABEL       = 8'd8;
	localparam int          NUM_CLASSES     = 4;

	localparam logic [7:0] CFG_CLASS_MAP = 8'd0;
	localparam logic [7:0] CFG_MIN_TOTAL = 8'd1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_HOME,
		ST_PROBE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic        mode;
		logic [63:0] seg_id;
		logic [7:0]  voxel_label;
		logic [9:0]  slot_index;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_seg_id;
		logic [31:0] dendrite_count;
		logic [31:0] axon_count;
		logic [31:0] glia_count;
		logic [31:0] unsure_count;
		logic        occupied;
		logic        passes;
		logic        table_full;
	} out_item_t;

endpackage

// ===== rtl/core/psch_hash.sv =====
// Multiplicative hash giving the home slot of a key; the partial products are registered.
module psch_hash import psch_pkg::*; #(
	parameter int SLOT_W = 10
) (
	input  logic              clk,
	input  logic [63:0]       key,
	output logic [SLOT_W-1:0] slot
);

	logic [63:0] p_ll_s1;
	logic [31:0] p_hl_s1;
	logic [31:0] p_lh_s1;
	logic [63:0] p_hl_full;
	logic [63:0] p_lh_full;
	logic [31:0] upper;

	assign p_hl_full = key[63:32] * HASH_MULT[31:0];
	assign p_lh_full = key[31:0] * HASH_MULT[63:32];

	always_ff @(posedge clk) begin
		p_ll_s1 <= key[31:0] * HASH_MULT[31:0];
		p_hl_s1 <= p_hl_full[31:0];
		p_lh_s1 <= p_lh_full[31:0];
	end

	assign upper = p_ll_s1[63:32] + p_hl_s1 + p_lh_s1;
	assign slot  = upper[SLOT_W-1:0];

endmodule

// ===== rtl/core/per_segment_class_histogram_unit.sv =====
// Top level of the per-segment class histogram unit.
// Count item: the key is hashed (ST_HASH, ST_HOME), then slots are probed in turn from home.
// Read item: the slot is read, then loaded into the output register once that is free.
// One item at a time; the next item is taken while a result waits in the output register.
// After reset a clearing pass frees every slot; no item is taken meanwhile. Configuration
// resets to its documented values. The user keeps TABLE_SLOTS a power of two; not enforced.
module per_segment_class_histogram_unit import psch_pkg::*; #(
	parameter int TABLE_SLOTS = 1024,
	parameter int COUNT_BITS  = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result,
	input  logic      cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SLOT_W  = $clog2(TABLE_SLOTS);
	localparam int CNT_W   = NUM_CLASSES * COUNT_BITS;
	localparam int ENTRY_W = 1 + 64 + CNT_W;
	localparam int USED_B  = ENTRY_W - 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

	logic [ENTRY_W-1:0] mem [TABLE_SLOTS];
	logic [ENTRY_W-1:0] rd_q;
	logic               re, we;
	logic [SLOT_W-1:0]  ra, wa;
	logic [ENTRY_W-1:0] wd;

	state_t            state_q, state_nx;
	logic [17:0]       class_map_q;
	logic [31:0]       min_total_q;
	logic [63:0]       key_q;
	logic [1:0]        cls_q;
	logic [SLOT_W-1:0] pos_q, pos_nx;
	logic [SLOT_W-1:0] n_q, n_nx;
	logic [SLOT_W-1:0] clr_q, clr_nx;
	logic              full_q, full_nx;
	logic              load;
	out_item_t         res_q;
	logic              res_valid_q;

	logic              accept;
	logic [SLOT_W-1:0] home;
	logic [4:0]        cls_idx;
	logic [SLOT_W-1:0] pos_inc;
	logic [63:0]       ent_key;
	logic              ent_used;
	logic [CNT_W-1:0]  cnt_new;
	logic [CNT_W-1:0]  cnt_inc;
	logic [COUNT_BITS-1:0] c [NUM_CLASSES];
	logic [65:0]       sum;
	out_item_t         res_nx;

	psch_hash #(.SLOT_W(SLOT_W)) u_hash (
		.clk  (clk),
		.key  (key_q),
		.slot (home)
	);

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rd_q <= mem[ra];
	end

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign cls_idx    = {item.voxel_label[3:0], 1'b0};
	assign pos_inc    = (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;
	assign ent_used   = rd_q[USED_B];
	assign ent_key    = rd_q[USED_B-1 -: 64];

	always_comb begin
		cnt_new = '0;
		cnt_inc = rd_q[CNT_W-1:0];
		for (int i = 0; i < NUM_CLASSES; i++) begin
			c[i] = rd_q[i*COUNT_BITS +: COUNT_BITS];
			if (cls_q == 2'(i)) begin
				cnt_new[i*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'(1);
				if (c[i] != '1)
					cnt_inc[i*COUNT_BITS +: COUNT_BITS] = c[i] + 1'b1;
			end
		end
	end

	always_comb begin
		sum = 66'(c[0]) + 66'(c[1]) + 66'(c[2]);
		res_nx = '0;
		if (ent_used) begin
			res_nx.out_seg_id     = ent_key;
			res_nx.dendrite_count = 32'(c[0]);
			res_nx.axon_count     = 32'(c[1]);
			res_nx.glia_count     = 32'(c[2]);
			res_nx.unsure_count   = 32'(c[3]);
			res_nx.occupied       = 1'b1;
			res_nx.passes         = (sum >= 66'(min_total_q));
		end
		res_nx.table_full = full_q;
	end

	always_comb begin
		state_nx = state_q;
		re       = 1'b0;
		ra       = pos_q;
		we       = 1'b0;
		wa       = pos_q;
		wd       = '0;
		pos_nx   = pos_q;
		n_nx     = n_q;
		clr_nx   = clr_q;
		full_nx  = full_q;
		load     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we     = 1'b1;
				wa     = clr_q;
				clr_nx = clr_q + 1'b1;
				if (clr_q == LAST_SLOT)
					state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (item.mode) begin
						re       = 1'b1;
						ra       = SLOT_W'(item.slot_index);
						state_nx = ST_READ;
					end else if (item.seg_id != '0 && item.voxel_label <= MAX_LABEL) begin
						state_nx = ST_HASH;
					end
				end
			end
			ST_HASH: state_nx = ST_HOME;
			ST_HOME: begin
				re       = 1'b1;
				ra       = home;
				pos_nx   = home;
				n_nx     = '0;
				state_nx = ST_PROBE;
			end
			ST_PROBE: begin
				priority if (!ent_used) begin
					we       = 1'b1;
					wd       = {1'b1, key_q, cnt_new};
					state_nx = ST_IDLE;
				end else if (ent_key == key_q) begin
					we       = 1'b1;
					wd       = {1'b1, key_q, cnt_inc};
					state_nx = ST_IDLE;
				end else if (n_q == LAST_SLOT) begin
					full_nx  = 1'b1;
					state_nx = ST_IDLE;
				end else begin
					re     = 1'b1;
					ra     = pos_inc;
					pos_nx = pos_inc;
					n_nx   = n_q + 1'b1;
				end
			end
			ST_READ: begin
				if (!res_valid_q || !result_stall) begin
					load     = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			full_q      <= 1'b0;
			res_valid_q <= 1'b0;
			class_map_q <= CLASS_MAP_RESET;
			min_total_q <= MIN_TOTAL_RESET;
		end else begin
			state_q <= state_nx;
			clr_q   <= clr_nx;
			full_q  <= full_nx;
			if (load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
			if (cfg_we && cfg_index == CFG_CLASS_MAP)
				class_map_q <= cfg_data[17:0];
			if (cfg_we && cfg_index == CFG_MIN_TOTAL)
				min_total_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_nx;
		n_q   <= n_nx;
		if (accept) begin
			key_q <= item.seg_id;
			cls_q <= class_map_q[cls_idx +: 2];
		end
		if (load)
			res_q <= res_nx;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== rtl/core/psch_checker.sv =====
// Port checker for the per-segment class histogram unit, with its bind.
`include "per_segment_class_histogram_unit_assert.svh"

module psch_checker import psch_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_stall,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	logic seen_full_q;
	logic free_zero;

	assign free_zero = result.out_seg_id == '0 && result.dendrite_count == '0 &&
		result.axon_count == '0 && result.glia_count == '0 &&
		result.unsure_count == '0 && !result.passes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_full_q <= 1'b0;
		else if (result_valid && result.table_full)
			seen_full_q <= 1'b1;
	end

	`PSCH_ASSERT_NXT(a_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))
	`PSCH_ASSERT_IMP(a_full_sticky, clk, arst_n, result_valid && seen_full_q, result.table_full)
	`PSCH_ASSERT_IMP(a_free_zero, clk, arst_n, result_valid && !result.occupied, free_zero)
	`PSCH_ASSERT_IMP(a_clear_stall, clk, arst_n, !$past(arst_n), item_stall && !result_valid)

endmodule

bind per_segment_class_histogram_unit psch_checker u_psch_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
